// ----- rtl/epbb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package epbb_pkg;

  localparam int unsigned POSITION_WIDTH_DEF = 16;
  localparam int unsigned TIMER_WIDTH_DEF    = 16;

  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEADBAND     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_POSITION = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STALL_LIMIT  = 2'd2;

  localparam logic [7:0]  DEADBAND_RST     = 8'd2;
  localparam logic [14:0] MAX_POSITION_RST = 15'd1000;
  localparam logic [15:0] STALL_LIMIT_RST  = 16'd500;

  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_TARGET = 2'd2;

  localparam logic [1:0] CMD_STOP    = 2'd0;
  localparam logic [1:0] CMD_FORWARD = 2'd1;
  localparam logic [1:0] CMD_REVERSE = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic               enc_a;
    logic               enc_b;
    logic signed [15:0] target_pos;
  } in_t;

  typedef struct packed {
    logic [1:0]         motor_cmd;
    logic signed [15:0] position;
    logic               stall_homed;
  } out_t;

  typedef struct packed {
    logic [7:0]  deadband;
    logic [14:0] max_position;
    logic [15:0] stall_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/encoder_position_bang_bang_control_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Quadrature encoder position counter with bang-bang position control and
// stall homing. Each input beat is an encoder edge, a control tick or a new
// target, and yields exactly one output beat carrying the motor command, the
// position and the homing flag. A beat is taken every cycle unless back-pressure
// on the output stalls it; its result is presented after the input register, one
// pass through the update logic and the result register. Configuration
// writes are taken at any time on their own channel and should be made only
// while no beat is in flight.
module encoder_position_bang_bang_control_unit #(
  parameter int unsigned POSITION_WIDTH = epbb_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned TIMER_WIDTH    = epbb_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire epbb_pkg::in_t                        in_data_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output epbb_pkg::out_t                            out_data_o,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [epbb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [epbb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  epbb_pkg::cfg_t cfg;
  epbb_pkg::in_t  in_q;
  epbb_pkg::out_t out_q;
  epbb_pkg::out_t result;
  logic           in_valid_q;
  logic           out_valid_q;
  logic           adv;

  logic signed [POSITION_WIDTH-1:0] count_q, count_d;
  logic signed [POSITION_WIDTH-1:0] goal_q, goal_d;
  logic [TIMER_WIDTH-1:0]           idle_q, idle_d;
  logic [1:0]                       drive_q, drive_d;

  epbb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  epbb_step #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIMER_WIDTH    (TIMER_WIDTH)
  ) u_step (
    .item_i   (in_q),
    .cfg_i    (cfg),
    .count_i  (count_q),
    .goal_i   (goal_q),
    .idle_i   (idle_q),
    .drive_i  (drive_q),
    .count_o  (count_d),
    .goal_o   (goal_d),
    .idle_o   (idle_d),
    .drive_o  (drive_d),
    .result_o (result)
  );

  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      goal_q      <= '0;
      idle_q      <= '0;
      drive_q     <= epbb_pkg::CMD_STOP;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
        goal_q      <= goal_d;
        idle_q      <= idle_d;
        drive_q     <= drive_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
  end

  a_homed_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && result.stall_homed |=> drive_q == epbb_pkg::CMD_FORWARD && count_q == goal_q)
    else $error("Homing left drive or goal inconsistent.");

  a_edge_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.kind == epbb_pkg::KIND_EDGE |=> idle_q == '0)
    else $error("Encoder edge did not clear the idle timer.");

  a_stop_clears_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.kind == epbb_pkg::KIND_TICK && drive_q != epbb_pkg::CMD_STOP &&
    result.motor_cmd == epbb_pkg::CMD_STOP |=> idle_q == '0)
    else $error("Stop on a tick did not clear the idle timer.");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("Input taken while both stages were held.");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o && out_data_o.motor_cmd == drive_q)
    else $error("Result command differs from the stored drive.");

endmodule

`default_nettype wire

// ----- rtl/epbb_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epbb_cfg (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_valid_i,
  input  wire logic [epbb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  wire logic [epbb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i,
  output epbb_pkg::cfg_t                            cfg_o
);

  epbb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        epbb_pkg::CFG_DEADBAND:     cfg_d.deadband     = cfg_data_i[7:0];
        epbb_pkg::CFG_MAX_POSITION: cfg_d.max_position = cfg_data_i[14:0];
        epbb_pkg::CFG_STALL_LIMIT:  cfg_d.stall_limit  = cfg_data_i[15:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband     <= epbb_pkg::DEADBAND_RST;
      cfg_q.max_position <= epbb_pkg::MAX_POSITION_RST;
      cfg_q.stall_limit  <= epbb_pkg::STALL_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/epbb_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module epbb_step #(
  parameter int unsigned POSITION_WIDTH = epbb_pkg::POSITION_WIDTH_DEF,
  parameter int unsigned TIMER_WIDTH    = epbb_pkg::TIMER_WIDTH_DEF
) (
  input  wire epbb_pkg::in_t               item_i,
  input  wire epbb_pkg::cfg_t              cfg_i,
  input  wire logic signed [POSITION_WIDTH-1:0] count_i,
  input  wire logic signed [POSITION_WIDTH-1:0] goal_i,
  input  wire logic [TIMER_WIDTH-1:0]      idle_i,
  input  wire logic [1:0]                  drive_i,
  output logic signed [POSITION_WIDTH-1:0] count_o,
  output logic signed [POSITION_WIDTH-1:0] goal_o,
  output logic [TIMER_WIDTH-1:0]           idle_o,
  output logic [1:0]                       drive_o,
  output epbb_pkg::out_t                   result_o
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned DW = (PW + 2 > 10) ? PW + 2 : 10;
  localparam int unsigned HW = ((PW > 15) ? PW : 15) + 1;
  localparam int unsigned CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  localparam logic [PW-1:0] PosMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic [PW-1:0] PosMin = {1'b1, {(PW-1){1'b0}}};
  localparam logic [TIMER_WIDTH-1:0] IdleMax = {TIMER_WIDTH{1'b1}};

  logic signed [PW-1:0]  count_step;
  logic [TIMER_WIDTH-1:0] idle_inc;
  logic signed [DW-1:0]  diff;
  logic signed [DW-1:0]  db;
  logic                  in_band;
  logic                  stalled;
  logic [HW-1:0]         home_wide;
  logic [PW-1:0]         home_pos;
  logic [14:0]           tgt_mag;
  logic [HW-1:0]         tgt_wide;
  logic [PW-1:0]         tgt_pos;
  logic                  homed;
  logic signed [PW+15:0] count_ext;

  always_comb begin
    if (item_i.enc_a ^ item_i.enc_b) begin
      count_step = (count_i == $signed(PosMax)) ? count_i : count_i + PW'(1);
    end else begin
      count_step = (count_i == $signed(PosMin)) ? count_i : count_i - PW'(1);
    end
  end

  assign idle_inc = (idle_i == IdleMax) ? idle_i : idle_i + TIMER_WIDTH'(1);
  assign diff     = DW'(count_i) - DW'(goal_i);
  assign db       = $signed(DW'(cfg_i.deadband));
  assign in_band  = (diff < db) && (diff > -db);
  assign stalled  = CW'(idle_inc) > CW'(cfg_i.stall_limit);

  assign home_wide = HW'(cfg_i.max_position);
  assign home_pos  = (home_wide > HW'(PosMax)) ? PosMax : home_wide[PW-1:0];
  assign tgt_mag   = item_i.target_pos[15] ? 15'd0 : item_i.target_pos[14:0];
  assign tgt_wide  = HW'(tgt_mag);
  assign tgt_pos   = (tgt_wide > HW'(PosMax)) ? PosMax : tgt_wide[PW-1:0];

  always_comb begin
    count_o = count_i;
    goal_o  = goal_i;
    idle_o  = idle_i;
    drive_o = drive_i;
    homed   = 1'b0;
    unique case (item_i.kind)
      epbb_pkg::KIND_EDGE: begin
        count_o = count_step;
        idle_o  = '0;
      end
      epbb_pkg::KIND_TICK: begin
        idle_o = idle_inc;
        if (in_band) begin
          drive_o = epbb_pkg::CMD_STOP;
          idle_o  = '0;
        end else if (diff > 0) begin
          drive_o = epbb_pkg::CMD_REVERSE;
        end else if (diff < 0) begin
          drive_o = epbb_pkg::CMD_FORWARD;
          if (stalled) begin
            count_o = $signed(home_pos);
            goal_o  = $signed(home_pos);
            homed   = 1'b1;
          end
        end
      end
      epbb_pkg::KIND_TARGET: begin
        goal_o = $signed(tgt_pos);
      end
      default: begin
        count_o = count_i;
      end
    endcase
  end

  assign count_ext            = (PW + 16)'(count_o);
  assign result_o.motor_cmd   = drive_o;
  assign result_o.position    = count_ext[15:0];
  assign result_o.stall_homed = homed;

endmodule

`default_nettype wire
